@@ rtl/core/drms_pkg.sv @@
// ----------------------------------------------------------------------------
// drms_pkg
// shared types, constants and helpers of the depth region minimum steering block
// ----------------------------------------------------------------------------
package drms_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int DIM_W         = 13;
    localparam int CNT_W         = 12;
    localparam int DEPTH_W       = 16;
    localparam int TURN_W        = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // reciprocal of three, exact for operands below 2**15
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    // register index, taken from paddr bit 2
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [DIM_W-1:0]   dim_t;

    typedef enum logic [TURN_W-1:0] {
        TURN_STRAIGHT = 2'd0,
        TURN_LEFT     = 2'd1,
        TURN_RIGHT    = 2'd2
    } turn_t;

    // zero acts as one, above the maximum acts as the maximum
    function automatic dim_t clamp_dim(input dim_t v);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (v > dim_t'(MAX_DIM))
        begin
            r = dim_t'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // floor(x / 3) by reciprocal multiply
    function automatic dim_t div3(input logic [DIM_W:0] x);
        logic [DIM_W+16:0] prod;
        prod = x * RECIP3;
        return prod[RECIP3_SHIFT+DIM_W-1:RECIP3_SHIFT];
    endfunction

endpackage

@@ rtl/core/drms_if.sv @@
// ----------------------------------------------------------------------------
// drms_pixel_if / drms_result_if
// valid/ready channels for depth pixels and steering results
// ----------------------------------------------------------------------------
interface drms_pixel_if;
    logic            valid;
    logic            ready;
    drms_pkg::depth_t depth;
    logic            frame_start;

    modport source (output valid, output depth, output frame_start, input ready);
    modport sink   (input valid, input depth, input frame_start, output ready);
endinterface

interface drms_result_if;
    logic                          valid;
    logic                          ready;
    logic [drms_pkg::TURN_W-1:0]   turn;
    drms_pkg::depth_t              min_overall;
    drms_pkg::depth_t              min_left;
    drms_pkg::depth_t              min_right;
    drms_pkg::depth_t              min_center;

    modport source (output valid, output turn, output min_overall, output min_left,
                    output min_right, output min_center, input ready);
    modport sink   (input valid, input turn, input min_overall, input min_left,
                    input min_right, input min_center, output ready);
endinterface

@@ rtl/core/depth_region_min_steer_top.sv @@
// ----------------------------------------------------------------------------
// depth_region_min_steer_top
// steering decision from band minima of a raster depth stream
// ----------------------------------------------------------------------------
// Takes one 16-bit depth pixel per clock in raster order and tracks column and
// row against the configured frame size (APB registers: width at 0x0, height
// at 0x4, zero acts as 1, values above 4096 act as 4096). Over the top half of
// the frame it keeps the overall minimum and the minima of the left, center
// and right column bands. On the last pixel of a frame one result item leaves
// with a turn code (0 straight, 1 left, 2 right) and the four minima. Every
// pixel item is taken at once: the running state updates at the
// accepting edge and a result lands in an output register, so a new pixel is
// accepted each clock as long as the output register is empty or being
// drained. frame_start restarts the position and minima on its own pixel.
// ----------------------------------------------------------------------------
module depth_region_min_steer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drms_pkg::PADDR_W-1:0]  paddr,
    input  logic [drms_pkg::PDATA_W-1:0]  pwdata,
    output logic [drms_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    drms_pixel_if.sink                    pixel,
    drms_result_if.source                 result
);

    // configuration registers and the bounds derived from them
    drms_pkg::dim_t width_reg;
    drms_pkg::dim_t height_reg;
    drms_pkg::cnt_t wm1_reg;        // last column
    drms_pkg::cnt_t third_reg;      // left band ends below this
    drms_pkg::cnt_t two_third_reg;  // right band starts above this
    drms_pkg::cnt_t half_reg;       // scanned rows lie below this
    drms_pkg::cnt_t hm1_reg;        // last row

    // running state
    drms_pkg::cnt_t   col_reg;
    drms_pkg::cnt_t   row_reg;
    drms_pkg::depth_t min_all_reg;
    drms_pkg::depth_t min_left_reg;
    drms_pkg::depth_t min_right_reg;
    drms_pkg::depth_t min_center_reg;

    // output register
    logic                        out_valid_reg;
    logic [drms_pkg::TURN_W-1:0] turn_reg;
    drms_pkg::depth_t            out_all_reg;
    drms_pkg::depth_t            out_left_reg;
    drms_pkg::depth_t            out_right_reg;
    drms_pkg::depth_t            out_center_reg;

    logic           cfg_write;
    drms_pkg::dim_t wr_clamped;
    drms_pkg::dim_t wr_third;
    drms_pkg::dim_t wr_two_third;

    logic             accept;
    drms_pkg::cnt_t   col_cur;
    drms_pkg::cnt_t   row_cur;
    drms_pkg::depth_t all_cur;
    drms_pkg::depth_t left_cur;
    drms_pkg::depth_t right_cur;
    drms_pkg::depth_t center_cur;
    drms_pkg::depth_t all_next;
    drms_pkg::depth_t left_next;
    drms_pkg::depth_t right_next;
    drms_pkg::depth_t center_next;
    logic             scan_row;
    logic             below_min;
    logic             last_col;
    logic             last_row;
    drms_pkg::turn_t  turn_next;

    // ---------------------------------------------------------------- apb
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // bounds for the value being written, so they are ready with the register
    always_comb
    begin
        wr_clamped   = drms_pkg::clamp_dim(pwdata[drms_pkg::DIM_W-1:0]);
        wr_third     = drms_pkg::div3({1'b0, wr_clamped});
        wr_two_third = drms_pkg::div3({wr_clamped, 1'b0});
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            drms_pkg::REG_WIDTH:  prdata = {{(drms_pkg::PDATA_W-drms_pkg::DIM_W){1'b0}}, width_reg};
            drms_pkg::REG_HEIGHT: prdata = {{(drms_pkg::PDATA_W-drms_pkg::DIM_W){1'b0}}, height_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= drms_pkg::WIDTH_RESET;
            height_reg    <= drms_pkg::HEIGHT_RESET;
            wm1_reg       <= drms_pkg::cnt_t'(drms_pkg::WIDTH_RESET - 13'd1);
            third_reg     <= drms_pkg::cnt_t'(drms_pkg::div3({1'b0, drms_pkg::WIDTH_RESET}));
            two_third_reg <= drms_pkg::cnt_t'(drms_pkg::div3({drms_pkg::WIDTH_RESET, 1'b0}));
            half_reg      <= drms_pkg::cnt_t'(drms_pkg::HEIGHT_RESET >> 1);
            hm1_reg       <= drms_pkg::cnt_t'(drms_pkg::HEIGHT_RESET - 13'd1);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == drms_pkg::REG_WIDTH)
            begin
                width_reg     <= pwdata[drms_pkg::DIM_W-1:0];
                wm1_reg       <= drms_pkg::cnt_t'(wr_clamped - 13'd1);
                third_reg     <= drms_pkg::cnt_t'(wr_third);
                two_third_reg <= drms_pkg::cnt_t'(wr_two_third);
            end
            else
            begin
                height_reg <= pwdata[drms_pkg::DIM_W-1:0];
                half_reg   <= drms_pkg::cnt_t'(wr_clamped >> 1);
                hm1_reg    <= drms_pkg::cnt_t'(wr_clamped - 13'd1);
            end
        end
    end

    // ---------------------------------------------------------------- pixel path
    // the output register frees up in the same cycle it is drained
    assign pixel.ready = !out_valid_reg || result.ready;
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        // frame start clears position and minima before this pixel counts
        if (pixel.frame_start)
        begin
            col_cur    = '0;
            row_cur    = '0;
            all_cur    = drms_pkg::DEPTH_MAX;
            left_cur   = drms_pkg::DEPTH_MAX;
            right_cur  = drms_pkg::DEPTH_MAX;
            center_cur = drms_pkg::DEPTH_MAX;
        end
        else
        begin
            col_cur    = col_reg;
            row_cur    = row_reg;
            all_cur    = min_all_reg;
            left_cur   = min_left_reg;
            right_cur  = min_right_reg;
            center_cur = min_center_reg;
        end

        scan_row  = row_cur < half_reg;
        below_min = pixel.depth < all_cur;

        all_next    = (scan_row && below_min) ? pixel.depth : all_cur;
        left_next   = (scan_row && col_cur < third_reg && pixel.depth < left_cur)
                      ? pixel.depth : left_cur;
        right_next  = (scan_row && col_cur > two_third_reg && pixel.depth < right_cur)
                      ? pixel.depth : right_cur;
        center_next = (scan_row && col_cur >= third_reg && col_cur <= two_third_reg
                       && pixel.depth < center_cur) ? pixel.depth : center_cur;

        // at or past the bound ends the row or frame, covers mid-frame resizing
        last_col = col_cur >= wm1_reg;
        last_row = row_cur >= hm1_reg;

        if (right_next < left_next)
        begin
            turn_next = drms_pkg::TURN_RIGHT;
        end
        else if (left_next < right_next)
        begin
            turn_next = drms_pkg::TURN_LEFT;
        end
        else
        begin
            turn_next = drms_pkg::TURN_STRAIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            min_all_reg    <= drms_pkg::DEPTH_MAX;
            min_left_reg   <= drms_pkg::DEPTH_MAX;
            min_right_reg  <= drms_pkg::DEPTH_MAX;
            min_center_reg <= drms_pkg::DEPTH_MAX;
        end
        else if (accept)
        begin
            if (last_col && last_row)
            begin
                // frame done: wrap so the next pixel opens a new frame
                col_reg        <= '0;
                row_reg        <= '0;
                min_all_reg    <= drms_pkg::DEPTH_MAX;
                min_left_reg   <= drms_pkg::DEPTH_MAX;
                min_right_reg  <= drms_pkg::DEPTH_MAX;
                min_center_reg <= drms_pkg::DEPTH_MAX;
            end
            else
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_cur + 12'd1;
                end
                else
                begin
                    col_reg <= col_cur + 12'd1;
                    row_reg <= row_cur;
                end
                min_all_reg    <= all_next;
                min_left_reg   <= left_next;
                min_right_reg  <= right_next;
                min_center_reg <= center_next;
            end
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && last_col && last_row)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload loads only with a new result item, holds while stalled
    always_ff @(posedge clk)
    begin
        if (accept && last_col && last_row)
        begin
            turn_reg       <= turn_next;
            out_all_reg    <= all_next;
            out_left_reg   <= left_next;
            out_right_reg  <= right_next;
            out_center_reg <= center_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.turn        = turn_reg;
    assign result.min_overall = out_all_reg;
    assign result.min_left    = out_left_reg;
    assign result.min_right   = out_right_reg;
    assign result.min_center  = out_center_reg;

endmodule

@@ sim/depth_region_min_steer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_region_min_steer_top_tb
// self-checking bench for the depth band minimum steering block
// ----------------------------------------------------------------------------
// Streams raster depth pixels through the pixel channel and programs the frame
// size over the register port while the block is idle. A behavioral tracker of
// position, band minima and turn decision runs beside the block. It queues one
// expected steering item per completed frame, and every result item is
// compared field by field with the oldest entry. Directed frames come first:
// reset size, single-row frames, band split, restart and size clamping. Then
// random frames follow, with tie-prone and extreme depths, cut-short frames,
// stray frame starts and size changes in the middle of a frame. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module depth_region_min_steer_top_tb;

    localparam int unsigned RANDOM_PIXELS = 950;
    localparam int unsigned STALL_LIMIT   = 1000;

    // one steering decision with its four minima
    typedef struct packed {
        drms_pkg::turn_t  turn;
        drms_pkg::depth_t min_overall;
        drms_pkg::depth_t min_left;
        drms_pkg::depth_t min_right;
        drms_pkg::depth_t min_center;
    } steer_t;

    logic clk = 1'b0;
    logic rst_n;

    // register port
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [drms_pkg::PADDR_W-1:0] paddr;
    logic [drms_pkg::PDATA_W-1:0] pwdata;
    logic [drms_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    drms_pixel_if  pix ();
    drms_result_if res ();

    depth_region_min_steer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixel   (pix),
        .result  (res)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // tracker copy of the frame size registers
    drms_pkg::dim_t cfg_width  = drms_pkg::WIDTH_RESET;
    drms_pkg::dim_t cfg_height = drms_pkg::HEIGHT_RESET;

    // tracker copy of position and running minima
    drms_pkg::cnt_t   col_pos    = '0;
    drms_pkg::cnt_t   row_pos    = '0;
    drms_pkg::depth_t run_all    = drms_pkg::DEPTH_MAX;
    drms_pkg::depth_t run_left   = drms_pkg::DEPTH_MAX;
    drms_pkg::depth_t run_right  = drms_pkg::DEPTH_MAX;
    drms_pkg::depth_t run_center = drms_pkg::DEPTH_MAX;

    // steering items still owed by the block, oldest first
    steer_t pending_steer[$];

    int unsigned pixels_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes   = 0;
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;

    // when set, neither side idles
    bit steady_stream = 1'b0;

    task automatic flag_error(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // zero acts as one, above the maximum acts as the maximum
    function automatic int unsigned active_size(input drms_pkg::dim_t v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > drms_pkg::dim_t'(drms_pkg::MAX_DIM))
        begin
            return drms_pkg::MAX_DIM;
        end
        return int'(v);
    endfunction

    task automatic restart_frame();
        col_pos    = '0;
        row_pos    = '0;
        run_all    = drms_pkg::DEPTH_MAX;
        run_left   = drms_pkg::DEPTH_MAX;
        run_right  = drms_pkg::DEPTH_MAX;
        run_center = drms_pkg::DEPTH_MAX;
    endtask

    // advance the tracker by one accepted pixel, queue a result on frame end
    task automatic track_pixel(input drms_pkg::depth_t d, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned third;
        int unsigned two_third;
        steer_t      r;
        w         = active_size(cfg_width);
        h         = active_size(cfg_height);
        third     = w / 3;
        two_third = (2 * w) / 3;
        if (fs)
        begin
            restart_frame();
        end
        // only the top half of the frame feeds the minima
        if (row_pos < h / 2)
        begin
            if (d < run_all)
                run_all = d;
            if (col_pos < third && d < run_left)
                run_left = d;
            if (col_pos > two_third && d < run_right)
                run_right = d;
            if (col_pos >= third && col_pos <= two_third && d < run_center)
                run_center = d;
        end
        // at-or-past tests keep a shrunk frame from running away
        if (col_pos >= w - 1 && row_pos >= h - 1)
        begin
            if (run_right < run_left)
                r.turn = drms_pkg::TURN_RIGHT;
            else if (run_left < run_right)
                r.turn = drms_pkg::TURN_LEFT;
            else
                r.turn = drms_pkg::TURN_STRAIGHT;
            r.min_overall = run_all;
            r.min_left    = run_left;
            r.min_right   = run_right;
            r.min_center  = run_center;
            pending_steer.push_back(r);
            restart_frame();
        end
        else if (col_pos >= w - 1)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // present one pixel after a random gap and hold it until taken;
    // valid stays high so back-to-back pixels need no second assignment
    task automatic drive_pixel(input drms_pkg::depth_t d, input logic fs);
        int unsigned gap;
        gap = steady_stream ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.depth       <= d;
        pix.frame_start <= fs;
        do
            @(posedge clk);
        while (pix.ready !== 1'b1);
        track_pixel(d, fs);
        pixels_sent++;
    endtask

    // stop sending and wait until every owed result has come back
    task automatic quiesce();
        pix.valid <= 1'b0;
        while (pending_steer.size() != 0)
            @(posedge clk);
        // pixels that end no frame may still be settling
        repeat (4) @(posedge clk);
    endtask

    // two-phase register write, upper data bits carry noise
    task automatic write_dim(input logic reg_sel, input drms_pkg::dim_t value);
        logic [drms_pkg::PDATA_W-1:0] word;
        word                      = $urandom;
        word[drms_pkg::DIM_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == drms_pkg::REG_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        cfg_writes++;
        // bus turnaround before anything else
        @(posedge clk);
    endtask

    // a few pixels at the reset size, then shrink to 1x1 so the
    // partial frame closes on the next pixel
    task automatic test_default_size();
        drive_pixel(16'd900, 1'b1);
        drive_pixel(16'd450, 1'b0);
        drive_pixel(16'd700, 1'b0);
        quiesce();
        write_dim(drms_pkg::REG_WIDTH, drms_pkg::dim_t'(1));
        write_dim(drms_pkg::REG_HEIGHT, drms_pkg::dim_t'(1));
        drive_pixel(16'd5, 1'b0);
        quiesce();
    endtask

    // 1x1 frames: no row is scanned, every minimum stays at full scale
    task automatic test_single_row();
        drive_pixel(16'd0, 1'b1);
        drive_pixel(16'hFFFF, 1'b0);
        quiesce();
    endtask

    // 4x2 frame: one pixel per band plus the extremes, right band nearest
    task automatic test_band_split();
        write_dim(drms_pkg::REG_WIDTH, drms_pkg::dim_t'(4));
        write_dim(drms_pkg::REG_HEIGHT, drms_pkg::dim_t'(2));
        drive_pixel(16'd100, 1'b1);
        drive_pixel(16'hFFFF, 1'b0);
        drive_pixel(16'd0, 1'b0);
        drive_pixel(16'd50, 1'b0);
        // bottom half is ignored
        drive_pixel(16'd0, 1'b0);
        drive_pixel(16'hFFFF, 1'b0);
        drive_pixel(16'd7, 1'b0);
        drive_pixel(16'd1, 1'b0);
        quiesce();
    endtask

    // frame start on a pixel mid-frame throws the partial frame away
    task automatic test_frame_restart();
        write_dim(drms_pkg::REG_WIDTH, drms_pkg::dim_t'(3));
        drive_pixel(16'd5, 1'b1);
        drive_pixel(16'd6, 1'b0);
        drive_pixel(16'd1, 1'b1);
        drive_pixel(16'd2, 1'b0);
        drive_pixel(16'd3, 1'b0);
        drive_pixel(16'd9, 1'b0);
        drive_pixel(16'd9, 1'b0);
        drive_pixel(16'd9, 1'b0);
        quiesce();
    endtask

    // zero and oversize registers, frame closed by shrinking mid-frame
    task automatic test_size_clamp();
        write_dim(drms_pkg::REG_WIDTH, drms_pkg::dim_t'(0));
        write_dim(drms_pkg::REG_HEIGHT, '1);
        drive_pixel(16'd40, 1'b1);
        drive_pixel(16'd30, 1'b0);
        quiesce();
        write_dim(drms_pkg::REG_HEIGHT, drms_pkg::dim_t'(2));
        drive_pixel(16'd10, 1'b0);
        quiesce();
        write_dim(drms_pkg::REG_WIDTH, '1);
        write_dim(drms_pkg::REG_HEIGHT, drms_pkg::dim_t'(drms_pkg::MAX_DIM));
        drive_pixel(16'd200, 1'b1);
        drive_pixel(16'hFFFF, 1'b0);
        quiesce();
        write_dim(drms_pkg::REG_WIDTH, drms_pkg::dim_t'(0));
        write_dim(drms_pkg::REG_HEIGHT, drms_pkg::dim_t'(0));
        drive_pixel(16'd3, 1'b0);
        quiesce();
    endtask

    // one frame at the current size, sometimes cut short or disturbed
    task automatic send_frame();
        int unsigned      len;
        int unsigned      kind;
        int unsigned      flavor;
        int unsigned      stray_pos;
        int unsigned      k;
        logic             fs;
        drms_pkg::depth_t d;
        len       = active_size(cfg_width) * active_size(cfg_height);
        kind      = $urandom_range(0, 9);
        flavor    = $urandom_range(0, 3);
        stray_pos = $urandom_range(0, len - 1);
        // cut short: the next frame start discards it
        if (kind == 0)
            len = $urandom_range(1, len);
        for (k = 0; k < len; k++)
        begin
            // kind 9 leans on the wrap after the previous frame end
            fs = (k == 0 && kind != 9) || (kind == 1 && k == stray_pos);
            case (flavor)
                0:       d = drms_pkg::depth_t'(1000 + $urandom_range(0, 2));
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       d = '0;
                        1:       d = drms_pkg::DEPTH_MAX;
                        2:       d = drms_pkg::depth_t'($urandom_range(0, 15));
                        default: d = drms_pkg::depth_t'($urandom);
                    endcase
                end
                default: d = drms_pkg::depth_t'($urandom);
            endcase
            drive_pixel(d, fs);
        end
    endtask

    // random sizes and frames, resized only between bursts
    task automatic test_random_frames();
        int unsigned    start_count;
        int unsigned    nframes;
        int unsigned    i;
        int unsigned    pick;
        drms_pkg::dim_t wv;
        drms_pkg::dim_t hv;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS)
        begin
            quiesce();
            steady_stream = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 15);
            wv = (pick == 0) ? drms_pkg::dim_t'(0) :
                 (pick == 1) ? drms_pkg::dim_t'($urandom_range(13, 40)) :
                               drms_pkg::dim_t'($urandom_range(1, 12));
            pick = $urandom_range(0, 15);
            hv = (pick == 0) ? drms_pkg::dim_t'(0) :
                 (pick == 1) ? drms_pkg::dim_t'($urandom_range(7, 10)) :
                               drms_pkg::dim_t'($urandom_range(1, 6));
            // partial frames carry over into the new size
            case ($urandom_range(0, 3))
                0:       write_dim(drms_pkg::REG_WIDTH, wv);
                1:       write_dim(drms_pkg::REG_HEIGHT, hv);
                default:
                begin
                    write_dim(drms_pkg::REG_WIDTH, wv);
                    write_dim(drms_pkg::REG_HEIGHT, hv);
                end
            endcase
            nframes = $urandom_range(2, 5);
            for (i = 0; i < nframes && pixels_sent - start_count < RANDOM_PIXELS; i++)
                send_frame();
        end
        steady_stream = 1'b0;
    endtask

    // result sink: random stall before each item, then ready until taken
    initial
    begin
        int unsigned stall;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady_stream ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res.valid === 1'b1 && res.ready === 1'b1));
        end
    end

    // compare every taken result item with the oldest owed one
    always @(posedge clk)
    begin
        steer_t want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            if (pending_steer.size() == 0)
            begin
                flag_error($sformatf("unexpected result item, turn %0d overall %0d",
                                     res.turn, res.min_overall));
            end
            else
            begin
                want = pending_steer.pop_front();
                results_seen++;
                if (res.turn !== want.turn)
                    flag_error($sformatf("item %0d turn got %0d want %0d",
                                         results_seen, res.turn, want.turn));
                if (res.min_overall !== want.min_overall)
                    flag_error($sformatf("item %0d min_overall got %0d want %0d",
                                         results_seen, res.min_overall, want.min_overall));
                if (res.min_left !== want.min_left)
                    flag_error($sformatf("item %0d min_left got %0d want %0d",
                                         results_seen, res.min_left, want.min_left));
                if (res.min_right !== want.min_right)
                    flag_error($sformatf("item %0d min_right got %0d want %0d",
                                         results_seen, res.min_right, want.min_right));
                if (res.min_center !== want.min_center)
                    flag_error($sformatf("item %0d min_center got %0d want %0d",
                                         results_seen, res.min_center, want.min_center));
            end
        end
    end

    // watchdog: too long with no pixel, result or register access taken
    always @(posedge clk)
    begin
        if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
            (res.valid === 1'b1 && res.ready === 1'b1) ||
            (psel === 1'b1 && penable === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d results still owed", pending_steer.size());
                $display("depth_region_min_steer_top test failed");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        pix.valid       <= 1'b0;
        pix.depth       <= '0;
        pix.frame_start <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_single_row();
        test_band_split();
        test_frame_restart();
        test_size_clamp();
        test_random_frames();

        // drain, then let the output register settle
        quiesce();
        repeat (8) @(posedge clk);

        $display("%0d depth pixels, %0d steering results, %0d register writes",
                 pixels_sent, results_seen, cfg_writes);
        $display("band split, restarts, clamped and shrunk sizes; %0d mismatches",
                 error_count);
        if (error_count == 0 && pending_steer.size() == 0)
        begin
            $display("depth_region_min_steer_top test passed");
        end
        else
        begin
            $display("depth_region_min_steer_top test failed");
        end
        $finish;
    end

endmodule
